@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sorted key/value table checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while the reset is asserted.
`define SKVT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Assertion that is also checked while the reset is asserted.
`define SKVT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/skvt_pkg.sv @@
// ---------------------------------------------------------------------------
// Sorted key/value table package
// Shared types, codes and sizes of the sorted key/value table.
// ---------------------------------------------------------------------------
`default_nettype none

package skvt_pkg;

  // Default number of entries.
  localparam int CAPACITY = 16;

  // Field widths.
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 5;

  // Positions merged by one first-level reduction group.
  localparam int GROUP_SIZE = 16;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_PRESENT  = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_GRP  = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp_en;
    logic shift_en;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ design/sorted_key_value_table.sv @@
// ---------------------------------------------------------------------------
// Sorted key/value table
// Keeps up to CAPACITY key/value pairs in ascending order of unsigned key and
// serves lookup and insert requests.
// ---------------------------------------------------------------------------
// Each request goes through four steps to a registered result: acceptance,
// a compare in which every cell compares its key with the request key, the
// first-level merge of the cell flags in groups of sixteen positions, and
// the final merge, which moves the entries on an insert and waits while the
// output register holds a result not yet taken. The next request is accepted
// in the cycle after the result is registered, so a new request is taken
// only once the last is through; a waiting result holds back the final merge
// of the next request, not its acceptance. An insert moves every larger entry
// up by one slot as the result is registered, each cell taking the entry of its
// lower neighbour. The position reported is the number of stored keys below
// the request key, which is both the index of a matching entry and the
// insertion point of a missing one; it is given modulo 32. The entry count
// is cleared by reset; the entries themselves hold nothing until written and
// need no clearing pass, so the block is ready in the first cycle after
// reset.
`default_nettype none

module sorted_key_value_table #(
  parameter int CAPACITY = skvt_pkg::CAPACITY
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     in_valid_i,
  output logic                                          in_ready_o,
  input  wire logic                                     opcode_i,
  input  wire logic        [skvt_pkg::KEY_W-1:0]        key_i,
  input  wire logic signed [skvt_pkg::VALUE_W-1:0]      entry_value_i,
  output logic                                          out_valid_o,
  input  wire logic                                     out_ready_i,
  output logic             [skvt_pkg::STATUS_W-1:0]     status_o,
  output logic             [skvt_pkg::POS_W-1:0]        position_o,
  output logic signed      [skvt_pkg::VALUE_W-1:0]      found_value_o
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int GS   = skvt_pkg::GROUP_SIZE;
  localparam int NGRP = (CAPACITY + GS) / GS;
  localparam int NPAD = NGRP * GS;
  localparam int KW   = skvt_pkg::KEY_W;
  localparam int VW   = skvt_pkg::VALUE_W;

  skvt_pkg::state_e state_q, state_d;

  // Request held for the duration of its processing.
  logic          req_op_q;
  logic [KW-1:0] req_key_q;
  logic [VW-1:0] req_val_q;

  logic [CW-1:0] count_q;

  // Cell row.
  skvt_pkg::cell_ctrl_t ctrl;
  logic [CAPACITY-1:0]  lt, eq, occ;
  logic [KW-1:0]        cell_key [CAPACITY];
  logic [VW-1:0]        cell_val [CAPACITY];

  // First-level merge, one register set per group.
  logic [NGRP-1:0] grp_eq_d, grp_eq_q;
  logic [CW-1:0]   grp_pos_d [NGRP];
  logic [CW-1:0]   grp_pos_q [NGRP];
  logic [VW-1:0]   grp_val_d [NGRP];
  logic [VW-1:0]   grp_val_q [NGRP];

  logic [CAPACITY+1:0] lt_ext;
  logic [NPAD-1:0]     bnd;
  logic [NPAD-1:0]     eq_pad;
  logic [VW-1:0]       hit_val [NPAD];

  // Final merge.
  logic                      hit;
  logic [CW-1:0]             fin_pos;
  logic [VW-1:0]             fin_val;
  logic [CW+4:0]             pos_ext;
  logic                      full;
  logic                      out_load;
  skvt_pkg::status_e         status_d;
  logic [VW-1:0]             found_d;

  // Output register.
  logic                         out_valid_q;
  skvt_pkg::status_e            status_q;
  logic [skvt_pkg::POS_W-1:0]   pos_q;
  logic [VW-1:0]                found_q;

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  assign in_ready_o = (state_q == skvt_pkg::S_IDLE);
  assign out_load   = (state_q == skvt_pkg::S_FIN) && (!out_valid_q || out_ready_i);
  assign full       = (count_q == CW'(CAPACITY));

  always_comb begin
    state_d = state_q;
    case (state_q)
      skvt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = skvt_pkg::S_CMP;
        end
      end
      skvt_pkg::S_CMP: begin
        state_d = skvt_pkg::S_GRP;
      end
      skvt_pkg::S_GRP: begin
        state_d = skvt_pkg::S_FIN;
      end
      skvt_pkg::S_FIN: begin
        if (out_load) begin
          state_d = skvt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = skvt_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skvt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_op_q  <= opcode_i;
      req_key_q <= key_i;
      req_val_q <= entry_value_i;
    end
  end

  // -------------------------------------------------------------------------
  // Cell row
  // -------------------------------------------------------------------------
  // The cells compare in the cycle after acceptance. An insert of an absent
  // key into a table with room moves the entries as the result is registered.
  assign ctrl.cmp_en   = (state_q == skvt_pkg::S_CMP);
  assign ctrl.shift_en = out_load && (req_op_q == skvt_pkg::OP_INSERT) && !hit && !full;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KW-1:0] prev_key;
    logic [VW-1:0] prev_val;
    logic          prev_lt;

    // The lowest cell has no neighbour below: it behaves as if one with a
    // smaller key were there, so it takes the new pair when it moves.
    if (i == 0) begin : g_first
      assign prev_key = req_key_q;
      assign prev_val = req_val_q;
      assign prev_lt  = 1'b1;
    end else begin : g_rest
      assign prev_key = cell_key[i-1];
      assign prev_val = cell_val[i-1];
      assign prev_lt  = lt[i-1];
    end

    assign occ[i] = (CW'(i) < count_q);

    skvt_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (occ[i]),
      .key_i      (req_key_q),
      .val_i      (req_val_q),
      .prev_key_i (prev_key),
      .prev_val_i (prev_val),
      .prev_lt_i  (prev_lt),
      .key_o      (cell_key[i]),
      .val_o      (cell_val[i]),
      .lt_o       (lt[i]),
      .eq_o       (eq[i])
    );
  end

  // -------------------------------------------------------------------------
  // Merge of the cell flags
  // -------------------------------------------------------------------------
  // The entries below the request key form a run from position zero, so the
  // position is where that run ends: the one place whose lower neighbour is
  // below the key and which itself is not.
  assign lt_ext = {1'b0, lt, 1'b1};
  assign eq_pad = NPAD'(eq);

  always_comb begin
    bnd = '0;
    for (int p = 0; p <= CAPACITY; p++) begin
      bnd[p] = lt_ext[p] & ~lt_ext[p+1];
    end
  end

  always_comb begin
    for (int p = 0; p < NPAD; p++) begin
      hit_val[p] = '0;
    end
    for (int p = 0; p < CAPACITY; p++) begin
      hit_val[p] = eq[p] ? cell_val[p] : '0;
    end
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_eq_d[g]  = 1'b0;
      grp_pos_d[g] = '0;
      grp_val_d[g] = '0;
      for (int j = 0; j < GS; j++) begin
        grp_eq_d[g]  = grp_eq_d[g] | eq_pad[g*GS+j];
        grp_val_d[g] = grp_val_d[g] | hit_val[g*GS+j];
        if (bnd[g*GS+j]) begin
          grp_pos_d[g] = grp_pos_d[g] | CW'(g*GS+j);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == skvt_pkg::S_GRP) begin
      grp_eq_q  <= grp_eq_d;
      grp_pos_q <= grp_pos_d;
      grp_val_q <= grp_val_d;
    end
  end

  always_comb begin
    hit     = 1'b0;
    fin_pos = '0;
    fin_val = '0;
    for (int g = 0; g < NGRP; g++) begin
      hit     = hit | grp_eq_q[g];
      fin_pos = fin_pos | grp_pos_q[g];
      fin_val = fin_val | grp_val_q[g];
    end
  end

  assign pos_ext = {5'b0, fin_pos};

  always_comb begin
    found_d = '0;
    if (req_op_q == skvt_pkg::OP_LOOKUP) begin
      if (hit) begin
        status_d = skvt_pkg::ST_HIT;
        found_d  = fin_val;
      end else begin
        status_d = skvt_pkg::ST_MISS;
      end
    end else if (hit) begin
      status_d = skvt_pkg::ST_PRESENT;
    end else if (full) begin
      status_d = skvt_pkg::ST_FULL;
    end else begin
      status_d = skvt_pkg::ST_INSERTED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl.shift_en) begin
      count_q <= count_q + CW'(1);
    end
  end

  // -------------------------------------------------------------------------
  // Output register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q <= status_d;
      pos_q    <= pos_ext[skvt_pkg::POS_W-1:0];
      found_q  <= found_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign position_o    = pos_q;
  assign found_value_o = found_q;

endmodule

`default_nettype wire

@@ design/skvt_cell.sv @@
// ---------------------------------------------------------------------------
// Sorted key/value table cell
// Holds one entry, compares it against the search key and, on an insert,
// keeps its entry, takes the new pair or takes the entry of its lower
// neighbour.
// ---------------------------------------------------------------------------
`default_nettype none

module skvt_cell (
  input  wire logic                              clk_i,
  input  wire skvt_pkg::cell_ctrl_t              ctrl_i,
  input  wire logic                              occ_i,
  input  wire logic [skvt_pkg::KEY_W-1:0]        key_i,
  input  wire logic [skvt_pkg::VALUE_W-1:0]      val_i,
  input  wire logic [skvt_pkg::KEY_W-1:0]        prev_key_i,
  input  wire logic [skvt_pkg::VALUE_W-1:0]      prev_val_i,
  input  wire logic                              prev_lt_i,
  output logic      [skvt_pkg::KEY_W-1:0]        key_o,
  output logic      [skvt_pkg::VALUE_W-1:0]      val_o,
  output logic                                   lt_o,
  output logic                                   eq_o
);

  logic [skvt_pkg::KEY_W-1:0]   key_q, key_d;
  logic [skvt_pkg::VALUE_W-1:0] val_q, val_d;
  logic                         lt_q, eq_q;

  // An entry below the new key stays; the first entry not below it takes the
  // new pair, and every entry above that takes its neighbour's entry.
  always_comb begin
    key_d = key_q;
    val_d = val_q;
    if (ctrl_i.shift_en && !lt_q) begin
      if (prev_lt_i) begin
        key_d = key_i;
        val_d = val_i;
      end else begin
        key_d = prev_key_i;
        val_d = prev_val_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
    if (ctrl_i.cmp_en) begin
      lt_q <= occ_i && (key_q < key_i);
      eq_q <= occ_i && (key_q == key_i);
    end
  end

  assign key_o = key_q;
  assign val_o = val_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

`default_nettype wire

@@ design/skvt_checker.sv @@
// ---------------------------------------------------------------------------
// Sorted key/value table checker
// Port-level checks of the sorted key/value table, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module skvt_checker #(
  parameter int CAPACITY = skvt_pkg::CAPACITY
) (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_ready_o,
  input wire logic                               out_valid_o,
  input wire logic                               out_ready_i,
  input wire logic [skvt_pkg::STATUS_W-1:0]      status_o,
  input wire logic [skvt_pkg::POS_W-1:0]         position_o,
  input wire logic [skvt_pkg::VALUE_W-1:0]       found_value_o
);

  // A result stays offered until it is taken.
  `SKVT_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")

  // One request at a time: acceptance closes the input side.
  `SKVT_ASSERT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "request accepted while busy")

  // Only a hit carries a value.
  `SKVT_ASSERT(a_value_on_hit, clk_i, rst_ni, out_valid_o && (status_o != skvt_pkg::ST_HIT) |-> found_value_o == '0, "value given without a hit")

  // The position never lies beyond the table.
  `SKVT_ASSERT(a_pos_range, clk_i, rst_ni, out_valid_o |-> (CAPACITY > 31) || (int'(position_o) <= CAPACITY), "position beyond the table")

  // No result is offered in the cycle after the reset has been seen.
  `SKVT_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o, "result offered in reset")

endmodule

bind sorted_key_value_table skvt_checker #(.CAPACITY(CAPACITY)) u_skvt_checker (.*);

`default_nettype wire
